// File: rtl/pcbg_pkg.sv
// Package for the pixel contrast, brightness and gamma block.
// Holds the beat types, register indexes and the constant log2/exp2 tables.
// Depends on nothing; used by pixel_contrast_brightness_gamma.
`default_nettype none

package pcbg_pkg;

   typedef struct packed {
      logic [7:0] chan_blue;
      logic [7:0] chan_green;
      logic [7:0] chan_red;
   } pix_in_type;

   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
   } pix_out_type;

   typedef enum logic [2:0] {
      REG_CONTRAST   = 3'd0,
      REG_BRIGHTNESS = 3'd1,
      REG_GAMMA      = 3'd2,
      REG_LUMA_ONLY  = 3'd3,
      REG_COLOR      = 3'd4
   } reg_index_type;

   typedef logic [255:0][18:0] log_tab_type;
   typedef logic [16:0][29:0]  root_tab_type;
   typedef logic [15:0][30:0]  nib_tab_type;

   // Integer log2 of x in Q.16: exponent in bits 18:16, sixteen fraction
   // bits from repeated squaring of the normalised mantissa.
   function automatic logic [18:0] log2_q16(input logic [7:0] x);
      logic [2:0]  e;
      logic [63:0] m;
      logic [15:0] frac;
      e = 3'd0;
      frac = 16'd0;
      for (int b = 1; b < 8; b++) begin
         if ((x >> b) != 8'd0) e = 3'(b);
      end
      m = 64'(x) << (15 - e);
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 15;
         frac = frac << 1;
         if (m >= 64'd65536) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return {e, frac};
   endfunction

   function automatic log_tab_type make_log_tab();
      log_tab_type t;
      for (int i = 0; i < 256; i++) t[i] = log2_q16(8'(i));
      return t;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (b > v) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // Entry i is 2^(-2^-i) in Q.30, built by chained floor square roots.
   function automatic root_tab_type make_root_tab();
      root_tab_type c;
      c[0] = 30'd536870912;
      for (int i = 1; i <= 16; i++) c[i] = 30'(isqrt64(64'(c[i-1]) << 30));
      return c;
   endfunction

   localparam log_tab_type  LOG_TAB  = make_log_tab();
   localparam logic [18:0]  LOG2_255 = LOG_TAB[255];
   localparam root_tab_type ROOT_TAB = make_root_tab();

   // The first four exp2 steps start from exactly 1.0, so their outcome
   // depends only on the top fraction nibble.
   function automatic nib_tab_type make_nib_tab();
      nib_tab_type t;
      logic [63:0] acc;
      for (int n = 0; n < 16; n++) begin
         acc = 64'd1 << 30;
         for (int i = 1; i <= 4; i++) begin
            if (((n >> (4 - i)) & 1) != 0) acc = (acc * 64'(ROOT_TAB[i])) >> 30;
         end
         t[n] = 31'(acc);
      end
      return t;
   endfunction

   localparam nib_tab_type NIB_TAB = make_nib_tab();

endpackage

`default_nettype wire

// File: rtl/pixel_contrast_brightness_gamma.sv
// Top level of the pixel contrast, brightness and gamma adjustment pipeline.
// Depends on pcbg_pkg for beat types, register indexes and constant tables.
`default_nettype none

// Channel   Direction  Handshake                 Beat
// req       in         req_valid / req_ready     pcbg_pkg::pix_in_type
// rsp       out        rsp_valid / rsp_ready     pcbg_pkg::pix_out_type
// csr       in/out     APB, pready always high   32-bit registers at 4*index
//
// Every beat passes through 29 register stages, and one pixel is taken in every
// cycle that the pipe advances.  Most of the stages hold the twelve exp2 multiply
// steps and the eight restoring division steps, one per stage.  All stages move
// together whenever the output stage is empty or being taken, so a stall freezes
// the whole pipe and nothing is lost.
// Synchronous reset clears the valid bits and sets the registers to their
// reset values; data registers are not reset.

module pixel_contrast_brightness_gamma (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  pcbg_pkg::pix_in_type  req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output pcbg_pkg::pix_out_type rsp_data,
   input  wire                   csr_psel,
   input  wire                   csr_penable,
   input  wire                   csr_pwrite,
   input  wire  [4:0]            csr_paddr,
   input  wire  [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int NST = 29;

   // Configuration registers.
   logic [15:0] contrast_ff;
   logic [15:0] bright_ff;
   logic [15:0] gamma_ff;
   logic        luma_ff;
   logic        color_ff;

   logic [2:0] reg_idx;
   assign reg_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         contrast_ff <= 16'd4096;
         bright_ff   <= 16'd0;
         gamma_ff    <= 16'd4096;
         luma_ff     <= 1'b0;
         color_ff    <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_idx)
            pcbg_pkg::REG_CONTRAST:   contrast_ff <= csr_pwdata[15:0];
            pcbg_pkg::REG_BRIGHTNESS: bright_ff   <= csr_pwdata[15:0];
            pcbg_pkg::REG_GAMMA:      gamma_ff    <= csr_pwdata[15:0];
            pcbg_pkg::REG_LUMA_ONLY:  luma_ff     <= csr_pwdata[0];
            pcbg_pkg::REG_COLOR:      color_ff    <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         pcbg_pkg::REG_CONTRAST:   csr_prdata = {16'd0, contrast_ff};
         pcbg_pkg::REG_BRIGHTNESS: csr_prdata = {16'd0, bright_ff};
         pcbg_pkg::REG_GAMMA:      csr_prdata = {16'd0, gamma_ff};
         pcbg_pkg::REG_LUMA_ONLY:  csr_prdata = {31'd0, luma_ff};
         pcbg_pkg::REG_COLOR:      csr_prdata = {31'd0, color_ff};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   // Shared control travelling with every beat: valid, gray mode, divisor.
   logic       valid_ff [1:NST];
   logic       gray_ff  [1:NST];
   logic [7:0] dvs_ff   [1:NST];

   // The whole pipe advances when the last stage is empty or being taken.
   logic adv;
   assign adv       = !valid_ff[NST] || rsp_ready;
   assign req_ready = adv;

   // Input steering.  In luma mode every lane raises V to the power and then
   // scales its own channel by V'/V; a black pixel takes V' unscaled.
   logic [7:0] chs [3];
   logic [7:0] vmax;
   logic       luma_mode;
   logic       scale_mode;
   logic [7:0] x_in [3];
   logic [7:0] c_in [3];
   logic [7:0] dvs_in;

   always_comb begin
      chs[0] = req_data.chan_blue;
      chs[1] = req_data.chan_green;
      chs[2] = req_data.chan_red;
      vmax = chs[0];
      if (chs[1] > vmax) vmax = chs[1];
      if (chs[2] > vmax) vmax = chs[2];
      luma_mode  = color_ff && luma_ff;
      scale_mode = luma_mode && (vmax != 8'd0);
      dvs_in     = scale_mode ? vmax : 8'd1;
      for (int i = 0; i < 3; i++) begin
         if (scale_mode) begin
            x_in[i] = vmax;
            c_in[i] = chs[i];
         end else if (luma_mode) begin
            x_in[i] = 8'd0;
            c_in[i] = 8'd1;
         end else begin
            x_in[i] = chs[i];
            c_in[i] = 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= NST; s++) valid_ff[s] <= 1'b0;
      end else if (adv) begin
         valid_ff[1] <= req_valid;
         for (int s = 2; s <= NST; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         gray_ff[1] <= !color_ff;
         dvs_ff[1]  <= dvs_in;
         for (int s = 2; s <= NST; s++) begin
            gray_ff[s] <= gray_ff[s-1];
            dvs_ff[s]  <= dvs_ff[s-1];
         end
      end
   end

   logic [7:0] q_out [3];

   for (genvar ln = 0; ln < 3; ln++) begin : g_lane
      logic [7:0]  x1_ff;
      logic [15:0] w_ff   [1:18];
      logic        xz_ff  [2:16];
      logic [18:0] neg2_ff;
      logic [22:0] t3_ff;
      logic [30:0] acc_ff [4:16];
      logic [6:0]  k_ff   [4:16];
      logic [11:0] fr_ff  [4:16];
      logic [16:0] p17_ff;
      logic [32:0] s18_ff;
      logic        pos18_ff;
      logic [48:0] n19_ff;
      logic [48:0] r_ff   [20:28];
      logic [7:0]  q_ff   [20:28];
      logic        sat_ff [20:28];
      logic [7:0]  qo_ff;

      logic [18:0] lx_in;
      logic [34:0] t_prod;
      logic [32:0] cp_prod;
      logic [34:0] s_in;
      logic [16:0] p_in;
      logic [49:0] r2_in;
      logic [49:0] half_in;
      logic [8:0]  qn_in;
      logic        up_in;

      always_comb begin
         lx_in   = pcbg_pkg::LOG_TAB[x1_ff];
         t_prod  = 35'(neg2_ff) * 35'(gamma_ff);
         if (gamma_ff == 16'd0) begin
            p_in = 17'd65536;
         end else if (xz_ff[16] || k_ff[16] > 7'd40) begin
            p_in = 17'd0;
         end else begin
            p_in = 17'(acc_ff[16] >> (6'd14 + k_ff[16][5:0]));
         end
         cp_prod = 33'(contrast_ff) * 33'(p17_ff);
         s_in    = $signed({2'b00, cp_prod}) + $signed({{3{bright_ff[15]}}, bright_ff, 16'd0});
         r2_in   = {1'b0, r_ff[28]} << 1;
         half_in = 50'(dvs_ff[28]) << 28;
         up_in   = (r2_in > half_in) || ((r2_in == half_in) && q_ff[28][0]);
         qn_in   = {1'b0, q_ff[28]} + {8'd0, up_in};
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            // Stage 1: steered input.
            x1_ff   <= x_in[ln];
            w_ff[1] <= 16'(c_in[ln]) * 16'd255;
            for (int s = 2; s <= 18; s++) w_ff[s] <= w_ff[s-1];

            // Stage 2: distance below full scale in the log domain.
            neg2_ff  <= (lx_in > pcbg_pkg::LOG2_255) ? 19'd0 : pcbg_pkg::LOG2_255 - lx_in;
            xz_ff[2] <= (x1_ff == 8'd0);
            for (int s = 3; s <= 16; s++) xz_ff[s] <= xz_ff[s-1];

            // Stage 3: scale by the exponent.
            t3_ff <= t_prod[34:12];

            // Stage 4: first four exp2 steps from the nibble table.
            acc_ff[4] <= pcbg_pkg::NIB_TAB[t3_ff[15:12]];
            k_ff[4]   <= t3_ff[22:16];
            fr_ff[4]  <= t3_ff[11:0];

            // Stages 5 to 16: one conditional root multiply each.
            for (int j = 0; j < 12; j++) begin
               if (fr_ff[4+j][11-j]) begin
                  acc_ff[5+j] <= 31'((61'(acc_ff[4+j]) * 61'(pcbg_pkg::ROOT_TAB[5+j])) >> 30);
               end else begin
                  acc_ff[5+j] <= acc_ff[4+j];
               end
               k_ff[5+j]  <= k_ff[4+j];
               fr_ff[5+j] <= fr_ff[4+j];
            end

            // Stage 17: power in Q.16.
            p17_ff <= p_in;

            // Stage 18: gain and offset in Q.28.
            s18_ff   <= s_in[32:0];
            pos18_ff <= !s_in[34] && (s_in != 35'd0);

            // Stage 19: numerator 255 * c * s.
            n19_ff <= pos18_ff ? 49'(s18_ff) * 49'(w_ff[18]) : 49'd0;

            // Stage 20: anything at or above 256 saturates.
            sat_ff[20] <= (n19_ff >= (49'(dvs_ff[19]) << 36));
            r_ff[20]   <= n19_ff;
            q_ff[20]   <= 8'd0;

            // Stages 21 to 28: restoring division, one quotient bit each.
            for (int m = 0; m < 8; m++) begin
               sat_ff[21+m] <= sat_ff[20+m];
               if (r_ff[20+m] >= (49'(dvs_ff[20+m]) << (35 - m))) begin
                  r_ff[21+m] <= r_ff[20+m] - (49'(dvs_ff[20+m]) << (35 - m));
                  q_ff[21+m] <= q_ff[20+m] | (8'd1 << (7 - m));
               end else begin
                  r_ff[21+m] <= r_ff[20+m];
                  q_ff[21+m] <= q_ff[20+m];
               end
            end

            // Stage 29: round half to even and saturate; in gray mode green and red are zero.
            if (ln != 0 && gray_ff[28]) begin
               qo_ff <= 8'd0;
            end else if (sat_ff[28] || qn_in[8]) begin
               qo_ff <= 8'd255;
            end else begin
               qo_ff <= qn_in[7:0];
            end
         end
      end

      assign q_out[ln] = qo_ff;
   end

   assign rsp_valid          = valid_ff[NST];
   assign rsp_data.out_blue  = q_out[0];
   assign rsp_data.out_green = q_out[1];
   assign rsp_data.out_red   = q_out[2];

endmodule

`default_nettype wire

// File: tb/sv/pcbg_checker.sv
// Checker for the pixel contrast, brightness and gamma block.
// Watches the req, rsp and csr ports, predicts each adjusted pixel and compares.
// Depends on pcbg_pkg for the beat types and register indexes.
module pcbg_checker (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_ready,
   input  pcbg_pkg::pix_in_type  req_data,
   input  wire                   rsp_valid,
   input  wire                   rsp_ready,
   input  pcbg_pkg::pix_out_type rsp_data,
   input  wire                   csr_psel,
   input  wire                   csr_penable,
   input  wire                   csr_pwrite,
   input  wire                   csr_pready,
   input  wire  [4:0]            csr_paddr,
   input  wire  [31:0]           csr_pwdata,
   output int                    error_count,
   output int                    pending_count
);

   logic [15:0] gain_q12;
   logic [15:0] offset_q12;
   logic [15:0] gamma_q12;
   logic        luma_mode;
   logic        colour_mode;
   logic [63:0] root_q30 [0:16];
   pcbg_pkg::pix_out_type expected_pixels [$];

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] trial;
      r = 64'd0;
      for (int bitpos = 31; bitpos >= 0; bitpos--) begin
         trial = r | (64'd1 << bitpos);
         if (trial * trial <= v) r = trial;
      end
      return r;
   endfunction

   function automatic logic [63:0] log2_frac16(input logic [7:0] x);
      logic [63:0] m;
      logic [63:0] frac;
      int          ex;
      ex = 0;
      for (int b = 1; b < 8; b++) if (x[b]) ex = b;
      m = 64'(x) << (15 - ex);
      frac = 64'd0;
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 15;
         frac = frac << 1;
         if (m >= 64'd65536) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return (64'(ex) << 16) | frac;
   endfunction

   // Normalised x/255 raised to the gamma exponent, Q.16.
   function automatic logic [63:0] pow_norm(input logic [7:0] x);
      logic [63:0] lx, lfull, log_gap, t, k, f, acc;
      if (gamma_q12 == 16'd0) return 64'd65536;
      if (x == 8'd0) return 64'd0;
      lx = log2_frac16(x);
      lfull = log2_frac16(8'd255);
      log_gap = (lx > lfull) ? 64'd0 : lfull - lx;
      t = (log_gap * 64'(gamma_q12)) >> 12;
      k = t >> 16;
      f = t & 64'hFFFF;
      acc = 64'd1 << 30;
      for (int i = 1; i <= 16; i++) begin
         if (f[16 - i]) acc = (acc * root_q30[i]) >> 30;
      end
      if (k > 64'd40) return 64'd0;
      return acc >> (14 + k);
   endfunction

   function automatic longint affine_q28(input logic [7:0] x);
      longint off;
      off = longint'($signed(offset_q12));
      return longint'(64'(gain_q12) * pow_norm(x)) + off * 65536;
   endfunction

   function automatic logic [7:0] round_scale(input longint s, input logic [63:0] c,
                                              input logic [63:0] v);
      logic [63:0] num, den, q, r;
      if (s <= 0 || v == 64'd0) return 8'd0;
      num = 64'(s) * 64'd255 * c;
      den = v << 28;
      q = num / den;
      r = num % den;
      if (2 * r > den || (2 * r == den && q[0])) q = q + 1;
      return (q > 64'd255) ? 8'd255 : q[7:0];
   endfunction

   function automatic pcbg_pkg::pix_out_type predict_pixel(input pcbg_pkg::pix_in_type p);
      pcbg_pkg::pix_out_type o;
      logic [7:0]  v;
      longint      s;
      o = '0;
      if (!colour_mode) begin
         o.out_blue = round_scale(affine_q28(p.chan_blue), 1, 1);
      end else if (luma_mode) begin
         v = p.chan_blue;
         if (p.chan_green > v) v = p.chan_green;
         if (p.chan_red > v) v = p.chan_red;
         s = affine_q28(v);
         if (v == 8'd0) begin
            o.out_blue = round_scale(s, 1, 1);
            o.out_green = o.out_blue;
            o.out_red = o.out_blue;
         end else begin
            o.out_blue = round_scale(s, 64'(p.chan_blue), 64'(v));
            o.out_green = round_scale(s, 64'(p.chan_green), 64'(v));
            o.out_red = round_scale(s, 64'(p.chan_red), 64'(v));
         end
      end else begin
         o.out_blue = round_scale(affine_q28(p.chan_blue), 1, 1);
         o.out_green = round_scale(affine_q28(p.chan_green), 1, 1);
         o.out_red = round_scale(affine_q28(p.chan_red), 1, 1);
      end
      return o;
   endfunction

   initial begin
      root_q30[0] = 64'd1 << 29;
      for (int i = 1; i <= 16; i++) root_q30[i] = floor_sqrt(root_q30[i-1] << 30);
      error_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      pcbg_pkg::pix_out_type want;
      if (reset) begin
         gain_q12 <= 16'd4096;
         offset_q12 <= 16'd0;
         gamma_q12 <= 16'd4096;
         luma_mode <= 1'b0;
         colour_mode <= 1'b1;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (pcbg_pkg::reg_index_type'(csr_paddr[4:2]))
               pcbg_pkg::REG_CONTRAST:   gain_q12 <= csr_pwdata[15:0];
               pcbg_pkg::REG_BRIGHTNESS: offset_q12 <= csr_pwdata[15:0];
               pcbg_pkg::REG_GAMMA:      gamma_q12 <= csr_pwdata[15:0];
               pcbg_pkg::REG_LUMA_ONLY:  luma_mode <= csr_pwdata[0];
               pcbg_pkg::REG_COLOR:      colour_mode <= csr_pwdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) expected_pixels.push_back(predict_pixel(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               error_count++;
               if (error_count <= 10) $display("Unexpected result beat %h", rsp_data);
            end else begin
               want = expected_pixels.pop_front();
               if (want.out_blue != rsp_data.out_blue || want.out_green != rsp_data.out_green
                   || want.out_red != rsp_data.out_red) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("Mismatch: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                              want.out_blue, want.out_green, want.out_red,
                              rsp_data.out_blue, rsp_data.out_green, rsp_data.out_red);
               end
            end
         end
         pending_count <= expected_pixels.size();
      end
   end
endmodule

// File: tb/sv/tb_top.sv
// Top of the testbench for pixel_contrast_brightness_gamma.
// Makes clock, reset, register writes and pixel beats; pcbg_checker judges them.
// Depends on pcbg_pkg, the block and pcbg_checker.
module tb_top;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   pcbg_pkg::pix_in_type  req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   pcbg_pkg::pix_out_type rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [4:0]            csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;
   int                    error_count;
   int                    pending_count;

   // Set by the stimulus: quiet switches all idling off, long_hold asks the
   // receiver for one long stall while the sender keeps offering beats.
   bit          quiet;
   bit          long_hold;
   bit          hold_done;

   pixel_contrast_brightness_gamma uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   pcbg_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // A generous ceiling on the run; a correct run finishes far sooner.
   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver: random stalls in bursts, plus one long stall, long enough for
   // the 29-stage pipe to fill and push back.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // One register write: a setup phase, then the access phase, ended once
   // pready is seen with the access phase.
   task automatic write_reg(input pcbg_pkg::reg_index_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Waits until every predicted pixel has come out, then lets the pipe's
   // latency pass again before the registers may be touched.
   task automatic drain_pipe();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (35) @(posedge clock);
   endtask

   task automatic set_mode(input logic [15:0] gain, input logic [15:0] offset,
                           input logic [15:0] gam, input bit luma, input bit colour);
      drain_pipe();
      write_reg(pcbg_pkg::REG_CONTRAST, {16'(~gain), gain});
      write_reg(pcbg_pkg::REG_BRIGHTNESS, {16'(~offset), offset});
      write_reg(pcbg_pkg::REG_GAMMA, {16'(~gam), gam});
      write_reg(pcbg_pkg::REG_LUMA_ONLY, {31'($urandom), luma});
      write_reg(pcbg_pkg::REG_COLOR, {31'($urandom), colour});
   endtask

   // Offers one pixel beat, after an optional idle burst, and returns at the
   // edge where it is taken. Valid stays high into the next beat unless that beat starts with an idle burst.
   task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
      if (!quiet && !long_hold && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{chan_blue: b, chan_green: g, chan_red: r};
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(0, 8));
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_word(input logic [15:0] low_edge);
      case ($urandom_range(0, 5))
         0: return low_edge;
         1: return 16'hFFFF;
         2: return 16'h1000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random(input int count);
      logic [7:0] v;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            v = pick_byte();
            send_pixel(v, v, v);
         end else begin
            send_pixel(pick_byte(), pick_byte(), pick_byte());
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      quiet = 1'b0;
      long_hold = 1'b0;
      hold_done = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats at the reset settings: identity mapping, all extremes.
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd1, 8'd128, 8'd254);
      send_pixel(8'd255, 8'd0, 8'd77);

      // Zero gamma maps every value, black included, to full scale.
      set_mode(16'h1000, 16'h0000, 16'h0000, 1'b0, 1'b1);
      send_pixel(8'd0, 8'd1, 8'd255);
      // Luma mode on colour pixels, with a black pixel among them.
      set_mode(16'h1800, 16'hFC00, 16'h0800, 1'b1, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd10, 8'd200, 8'd60);
      send_pixel(8'd255, 8'd1, 8'd0);
      set_mode(16'h0800, 16'h0400, 16'h0000, 1'b1, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd0);
      // Gray input: luma mode has no effect and green and red are ignored.
      set_mode(16'hFFFF, 16'h7FFF, 16'h0001, 1'b1, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd3, 8'd9);
      set_mode(16'h0000, 16'h8000, 16'hFFFF, 1'b0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd17, 8'd0, 8'd0);
      set_mode(16'h0000, 16'h7FFF, 16'hFFFF, 1'b0, 1'b1);
      send_pixel(8'd1, 8'd254, 8'd255);

      // Random phases with random register values, extremes often picked.
      for (int phase = 0; phase < 10; phase++) begin
         set_mode(pick_word(16'h0000), pick_word(16'h8000), pick_word(16'h0001),
                  1'($urandom), ($urandom_range(0, 3) != 0));
         if (phase == 3) begin
            // Long receiver stall with the sender pushing without gaps.
            long_hold = 1'b1;
            send_random(60);
            long_hold = 1'b0;
         end else begin
            if (phase >= 8) quiet = 1'b1;
            send_random(45);
         end
      end

      drain_pipe();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
